>>> rtl/vfa_pkg.sv
// Shared types and defaults for the fixed-point 3D vector ALU.
`default_nettype none

package vfa_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_MAGSQ = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/vector3_fixed_point_alu_top.sv
// Throughput: one item per cycle while the output buffer has room; four arithmetic stages,
// one square-root stage per root bit, one divide stage per quotient bit, then a two-entry
// output buffer.
// The whole pipe advances together whenever the output buffer has a free entry.
// Reset (rst, synchronous) clears all valid bits and the output buffer; data is not reset.
`default_nettype none

module vector3_fixed_point_alu_top #(
  parameter int COMP_WIDTH = vfa_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = vfa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid,
  output logic                              ready,
  input  wire logic [2:0]                   opcode,
  input  wire logic signed [COMP_WIDTH-1:0] a_x,
  input  wire logic signed [COMP_WIDTH-1:0] a_y,
  input  wire logic signed [COMP_WIDTH-1:0] a_z,
  input  wire logic signed [COMP_WIDTH-1:0] b_x,
  input  wire logic signed [COMP_WIDTH-1:0] b_y,
  input  wire logic signed [COMP_WIDTH-1:0] b_z,
  input  wire logic signed [COMP_WIDTH-1:0] scale_factor,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic signed [COMP_WIDTH-1:0]      res_x,
  output logic signed [COMP_WIDTH-1:0]      res_y,
  output logic signed [COMP_WIDTH-1:0]      res_z,
  output logic signed [COMP_WIDTH-1:0]      res_scalar,
  output logic [1:0]                        status
);

  import vfa_pkg::*;

  localparam int W     = COMP_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;
  localparam int SW    = 2 * W + 3;
  localparam int DEPTH = W + F + 1;
  localparam int L     = DEPTH - 1;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]         CMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         CMIN   = {1'b1, {(W-1){1'b0}}};

  // Clamp to the component range; msb of the result is the saturation flag
  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > SAT_HI) begin
      r = {1'b1, CMAX};
    end else if (x < SAT_LO) begin
      r = {1'b1, CMIN};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // Pipe advance: the output buffer has room
  logic       adv;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign adv   = (count != 2'd2);
  assign ready = adv;

  // ---------------- stage 1: operand select, add/sub ----------------
  op_t                  op_in;
  logic signed [W-1:0]  av [3];
  logic signed [W-1:0]  bv [3];
  logic signed [W-1:0]  ma [6];
  logic signed [W-1:0]  mb [6];
  logic signed [W:0]    as_c [3];

  assign op_in = op_t'(opcode);
  assign av[0] = a_x;
  assign av[1] = a_y;
  assign av[2] = a_z;
  assign bv[0] = b_x;
  assign bv[1] = b_y;
  assign bv[2] = b_z;

  // Multiplier pairs: lane i uses products 2i and 2i+1
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (op_in)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = scale_factor;
          mb[2*i] = bv[i];
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = av[i];
          mb[2*i] = bv[i];
        end
      end
      OP_CROSS: begin
        ma[0] = a_y; mb[0] = b_z;
        ma[1] = b_y; mb[1] = a_z;
        ma[2] = a_z; mb[2] = b_x;
        ma[3] = b_z; mb[3] = a_x;
        ma[4] = a_x; mb[4] = b_y;
        ma[5] = b_x; mb[5] = a_y;
      end
      OP_MAGSQ, OP_MAG, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = av[i];
          mb[2*i] = av[i];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      if (op_in == OP_SUB) begin
        as_c[i] = {av[i][W-1], av[i]} - {bv[i][W-1], bv[i]};
      end else begin
        as_c[i] = {av[i][W-1], av[i]} + {bv[i][W-1], bv[i]};
      end
    end
  end

  logic                v1, v2, v3, v4;
  op_t                 op1, op2, op3, op4;
  logic signed [W-1:0] opa1 [6];
  logic signed [W-1:0] opb1 [6];
  logic signed [W:0]   as1 [3];
  logic signed [W:0]   as2 [3];
  logic signed [W:0]   as3 [3];
  logic signed [W-1:0] a1 [3];
  logic signed [W-1:0] a2 [3];
  logic signed [W-1:0] a3 [3];
  logic signed [PW-1:0] prod2 [6];
  logic signed [PW:0]   diff3 [3];

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stages 1-3: operands, products, lane differences
  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= op_in;
      for (int k = 0; k < 6; k++) begin
        opa1[k]  <= ma[k];
        opb1[k]  <= mb[k];
        prod2[k] <= opa1[k] * opb1[k];
      end
      op2 <= op1;
      op3 <= op2;
      for (int i = 0; i < 3; i++) begin
        as1[i]   <= as_c[i];
        as2[i]   <= as1[i];
        as3[i]   <= as2[i];
        a1[i]    <= av[i];
        a2[i]    <= a1[i];
        a3[i]    <= a2[i];
        diff3[i] <= {prod2[2*i][PW-1], prod2[2*i]} - {prod2[2*i+1][PW-1], prod2[2*i+1]};
      end
    end
  end

  // ---------------- stage 4: lane clamp, dot sum ----------------
  logic [W:0]           lane_c [3];
  logic signed [SW-1:0] dsum_c;
  logic [W-1:0]         mag_c [3];
  logic [2:0]           neg_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (op3)
        OP_ADD, OP_SUB:    lane_c[i] = sat_fn(SW'(as3[i]));
        OP_SCALE, OP_CROSS: lane_c[i] = sat_fn(SW'(diff3[i]) >>> F);
        default:           lane_c[i] = '0;
      endcase
      mag_c[i] = a3[i][W-1] ? W'(-a3[i]) : a3[i];
      neg_c[i] = a3[i][W-1];
    end
    dsum_c = SW'(diff3[0]) + SW'(diff3[1]) + SW'(diff3[2]);
  end

  logic signed [W-1:0]  lres4 [3];
  logic                 lflag4;
  logic signed [SW-1:0] dsum4;
  logic [W-1:0]         mag4 [3];
  logic [2:0]           neg4;

  always_ff @(posedge clk) begin
    if (adv) begin
      op4    <= op3;
      lflag4 <= lane_c[0][W] | lane_c[1][W] | lane_c[2][W];
      dsum4  <= dsum_c;
      neg4   <= neg_c;
      for (int i = 0; i < 3; i++) begin
        lres4[i] <= lane_c[i][W-1:0];
        mag4[i]  <= mag_c[i];
      end
    end
  end

  // Scalar clamp for dot and squared magnitude
  logic [W:0] scal_c;
  logic       scal_on;

  assign scal_c  = sat_fn(dsum4 >>> F);
  assign scal_on = (op4 == OP_DOT) || (op4 == OP_MAGSQ);

  // ---------------- side line alongside root and divide ----------------
  logic                sb_vld  [DEPTH];
  op_t                 sb_op   [DEPTH];
  logic signed [W-1:0] sb_res  [DEPTH][3];
  logic signed [W-1:0] sb_scal [DEPTH];
  logic                sb_flag [DEPTH];
  logic [2:0]          sb_neg  [DEPTH];
  logic [W-1:0]        sb_mag  [W][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        sb_vld[k] <= 1'b0;
      end
    end else if (adv) begin
      sb_vld[0] <= v4;
      for (int k = 1; k < DEPTH; k++) begin
        sb_vld[k] <= sb_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_op[0]   <= op4;
      sb_scal[0] <= scal_on ? scal_c[W-1:0] : '0;
      sb_flag[0] <= lflag4 | (scal_on & scal_c[W]);
      sb_neg[0]  <= neg4;
      for (int i = 0; i < 3; i++) begin
        sb_res[0][i] <= lres4[i];
        sb_mag[0][i] <= mag4[i];
      end
      for (int k = 1; k < DEPTH; k++) begin
        sb_op[k]   <= sb_op[k-1];
        sb_scal[k] <= sb_scal[k-1];
        sb_flag[k] <= sb_flag[k-1];
        sb_neg[k]  <= sb_neg[k-1];
        for (int i = 0; i < 3; i++) begin
          sb_res[k][i] <= sb_res[k-1][i];
        end
      end
      for (int k = 1; k < W; k++) begin
        for (int i = 0; i < 3; i++) begin
          sb_mag[k][i] <= sb_mag[k-1][i];
        end
      end
    end
  end

  // ---------------- square root and normalize divide ----------------
  logic [W-1:0]      root;
  logic [2:0][W-1:0] div_num;
  logic [2:0][F:0]   quo;
  logic [W-1:0]      den_end;

  vfa_sqrt #(.W(W)) u_sqrt (
    .clk      (clk),
    .en       (adv),
    .sq_in    (dsum4[PW-1:0]),
    .root_out (root)
  );

  assign div_num[0] = sb_mag[W-1][0];
  assign div_num[1] = sb_mag[W-1][1];
  assign div_num[2] = sb_mag[W-1][2];

  vfa_div #(.W(W), .F(F)) u_div (
    .clk     (clk),
    .en      (adv),
    .den_in  (root),
    .num_in  (div_num),
    .quo_out (quo),
    .den_out (den_end)
  );

  // ---------------- final select ----------------
  logic signed [W-1:0]  fin_res [3];
  logic signed [W-1:0]  fin_scal;
  status_t              fin_st;
  logic                 fin_flag;
  logic                 fin_zero;
  logic signed [SW-1:0] qx [3];
  logic [W:0]           qs [3];

  always_comb begin
    fin_flag = sb_flag[L];
    fin_zero = 1'b0;
    fin_scal = sb_scal[L];
    for (int i = 0; i < 3; i++) begin
      fin_res[i] = sb_res[L][i];
      qx[i]      = SW'(quo[i]);
      if (sb_neg[L][i]) begin
        qx[i] = -qx[i];
      end
      qs[i] = sat_fn(qx[i]);
    end
    case (sb_op[L])
      OP_MAG: begin
        fin_scal = den_end[W-1] ? CMAX : den_end;
        fin_flag = den_end[W-1];
      end
      OP_NORM: begin
        if (den_end == '0) begin
          fin_zero = 1'b1;
          for (int i = 0; i < 3; i++) begin
            fin_res[i] = '0;
          end
        end else begin
          fin_flag = qs[0][W] | qs[1][W] | qs[2][W];
          for (int i = 0; i < 3; i++) begin
            fin_res[i] = qs[i][W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (fin_zero) begin
      fin_st = ST_ZERO;
    end else if (fin_flag) begin
      fin_st = ST_SAT;
    end else begin
      fin_st = ST_OK;
    end
  end

  // ---------------- two-entry output buffer ----------------
  logic signed [W-1:0] ob_x [2];
  logic signed [W-1:0] ob_y [2];
  logic signed [W-1:0] ob_z [2];
  logic signed [W-1:0] ob_s [2];
  status_t             ob_st [2];
  logic                wr_ptr;
  logic                rd_ptr;

  assign push = adv & sb_vld[L];
  assign pop  = res_valid & res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_x[wr_ptr]  <= fin_res[0];
      ob_y[wr_ptr]  <= fin_res[1];
      ob_z[wr_ptr]  <= fin_res[2];
      ob_s[wr_ptr]  <= fin_scal;
      ob_st[wr_ptr] <= fin_st;
    end
  end

  assign res_valid  = (count != 2'd0);
  assign res_x      = ob_x[rd_ptr];
  assign res_y      = ob_y[rd_ptr];
  assign res_z      = ob_z[rd_ptr];
  assign res_scalar = ob_s[rd_ptr];
  assign status     = ob_st[rd_ptr];

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!adv && sb_vld[L]) |=> sb_vld[L])
    else $error("item lost at pipe end during stall");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_ZERO) |->
      (res_x == '0 && res_y == '0 && res_z == '0 && res_scalar == '0))
    else $error("zero-vector normalize gave nonzero result");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> res_valid)
    else $error("pushed item not presented");
`endif

endmodule

`default_nettype wire

>>> rtl/vfa_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module vfa_sqrt #(
  parameter int W = vfa_pkg::COMP_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] sq_in,
  output logic      [W-1:0]   root_out
);

  // Stage registers
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  // Stage inputs and one restoring step per stage
  logic [W-1:0]   rem_in  [W];
  logic [W-1:0]   root_in [W];
  logic [2*W-1:0] rad_in  [W];
  logic [W+1:0]   part    [W];
  logic [W+1:0]   trial   [W];
  logic           ge      [W];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = sq_in;
    for (int k = 1; k < W; k++) begin
      rem_in[k]  = rem_q[k-1][W-1:0];
      root_in[k] = root_q[k-1];
      rad_in[k]  = rad_q[k-1];
    end
    for (int k = 0; k < W; k++) begin
      part[k]  = {rem_in[k], rad_in[k][2*W-1 -: 2]};
      trial[k] = {root_in[k], 2'b01};
      ge[k]    = (part[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_q[k]  <= ge[k] ? (part[k] - trial[k]) : part[k];
        root_q[k] <= {root_in[k][W-2:0], ge[k]};
        rad_q[k]  <= {rad_in[k][2*W-3:0], 2'b00};
      end
    end
  end

  assign root_out = root_q[W-1];

endmodule

`default_nettype wire

>>> rtl/vfa_div.sv
// Pipelined three-lane divider for normalize, one quotient bit per stage.
`default_nettype none

module vfa_div #(
  parameter int W = vfa_pkg::COMP_WIDTH_DEF,
  parameter int F = vfa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [W-1:0]         den_in,
  input  wire logic [2:0][W-1:0]    num_in,
  output logic      [2:0][F:0]      quo_out,
  output logic      [W-1:0]         den_out
);

  localparam int D = F + 1;

  // Stage registers
  logic [W-1:0]      den_q [D];
  logic [2:0][W-1:0] rem_q [D];
  logic [2:0][F:0]   quo_q [D];

  // Per-stage compare and subtract; numerator never exceeds the divisor
  logic [W-1:0]      den_c  [D];
  logic [2:0][W:0]   part   [D];
  logic [2:0][W:0]   diff   [D];
  logic [2:0][F:0]   qprev  [D];
  logic [2:0]        ge     [D];
  logic [2:0][W-1:0] rem_nx [D];

  always_comb begin
    for (int j = 0; j < D; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          part[j][l]  = {1'b0, num_in[l]};
          qprev[j][l] = '0;
        end else begin
          part[j][l]  = {rem_q[j-1][l], 1'b0};
          qprev[j][l] = quo_q[j-1][l];
        end
      end
      den_c[j] = (j == 0) ? den_in : den_q[(j == 0) ? 0 : j-1];
      for (int l = 0; l < 3; l++) begin
        diff[j][l]   = part[j][l] - {1'b0, den_c[j]};
        ge[j][l]     = (part[j][l] >= {1'b0, den_c[j]});
        rem_nx[j][l] = ge[j][l] ? diff[j][l][W-1:0] : part[j][l][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < D; j++) begin
        den_q[j] <= den_c[j];
        for (int l = 0; l < 3; l++) begin
          rem_q[j][l] <= rem_nx[j][l];
          quo_q[j][l] <= {qprev[j][l][F-1:0], ge[j][l]};
        end
      end
    end
  end

  assign quo_out = quo_q[D-1];
  assign den_out = den_q[D-1];

endmodule

`default_nettype wire

>>> sim/vector3_fixed_point_alu_top_tb.sv
// Self-checking testbench for the fixed-point 3D vector ALU.
`timescale 1ns / 100ps
`default_nettype none

module vector3_fixed_point_alu_top_tb;
  import vfa_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LAT = W + F + 5;
  localparam int N_RAND = 2000;
  localparam longint CYC_LIMIT = 400000;

  typedef logic signed [W-1:0] comp_t;

  typedef struct packed {
    comp_t   x;
    comp_t   y;
    comp_t   z;
    comp_t   s;
    status_t st;
  } alu_res_t;

  typedef struct {
    op_t   op;
    comp_t ax, ay, az, bx, by, bz, sf;
  } alu_req_t;

  logic clk = 0;
  logic rst = 1;
  logic valid = 0;
  logic ready;
  logic [2:0] opcode = '0;
  comp_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0, scale_factor = '0;
  logic res_valid;
  logic res_ready = 0;
  comp_t res_x, res_y, res_z, res_scalar;
  logic [1:0] status;

  int err_count = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  int op_hits [8];

  vector3_fixed_point_alu_top dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .opcode(opcode),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .scale_factor(scale_factor), .res_valid(res_valid), .res_ready(res_ready),
    .res_x(res_x), .res_y(res_y), .res_z(res_z), .res_scalar(res_scalar),
    .status(status)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] exp_v);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, exp_v, cycles);
    err_count++;
  endtask

  // Saturate a wide signed value into the component range.
  function automatic comp_t clamp(input logic signed [129:0] v, inout bit satf);
    logic signed [129:0] hi_lim, lo_lim;
    hi_lim = (130'sd1 <<< (W - 1)) - 1;
    lo_lim = -(130'sd1 <<< (W - 1));
    if (v > hi_lim) begin
      satf = 1;
      return hi_lim[W-1:0];
    end
    if (v < lo_lim) begin
      satf = 1;
      return lo_lim[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic [129:0] root_floor(input logic [129:0] sq);
    logic [129:0] r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (130'd1 << b);
      if (c * c <= sq) r = c;
    end
    return r;
  endfunction

  // Compute the expected result of one ALU item.
  function automatic alu_res_t alu_predict(input alu_req_t q);
    alu_res_t r;
    bit satf;
    logic signed [129:0] ax, ay, az, bx, by, bz, sf, sum, mag, num, quo;
    comp_t ain [3];
    r = '0;
    satf = 0;
    ax = q.ax; ay = q.ay; az = q.az; bx = q.bx; by = q.by; bz = q.bz; sf = q.sf;
    case (q.op)
      OP_ADD: begin
        r.x = clamp(ax + bx, satf); r.y = clamp(ay + by, satf); r.z = clamp(az + bz, satf);
      end
      OP_SUB: begin
        r.x = clamp(ax - bx, satf); r.y = clamp(ay - by, satf); r.z = clamp(az - bz, satf);
      end
      OP_SCALE: begin
        r.x = clamp((sf * bx) >>> F, satf);
        r.y = clamp((sf * by) >>> F, satf);
        r.z = clamp((sf * bz) >>> F, satf);
      end
      OP_DOT: r.s = clamp((ax * bx + ay * by + az * bz) >>> F, satf);
      OP_CROSS: begin
        r.x = clamp((ay * bz - by * az) >>> F, satf);
        r.y = clamp((az * bx - bz * ax) >>> F, satf);
        r.z = clamp((ax * by - bx * ay) >>> F, satf);
      end
      OP_MAGSQ: r.s = clamp((ax * ax + ay * ay + az * az) >>> F, satf);
      OP_MAG: r.s = clamp($signed(root_floor(ax * ax + ay * ay + az * az)), satf);
      default: begin
        mag = $signed(root_floor(ax * ax + ay * ay + az * az));
        if (mag == 0) begin
          r.st = ST_ZERO;
          return r;
        end
        ain[0] = q.ax; ain[1] = q.ay; ain[2] = q.az;
        for (int i = 0; i < 3; i++) begin
          num = ain[i];
          if (num < 0) num = -num;
          quo = (num <<< F) / mag;
          if (ain[i] < 0) quo = -quo;
          if (i == 0) r.x = clamp(quo, satf);
          else if (i == 1) r.y = clamp(quo, satf);
          else r.z = clamp(quo, satf);
        end
      end
    endcase
    r.st = satf ? ST_SAT : ST_OK;
    return r;
  endfunction

  class alu_scoreboard;
    alu_res_t pending [$];

    function void note_item(alu_req_t q);
      pending.push_back(alu_predict(q));
    endfunction

    task check_result(alu_res_t got);
      alu_res_t want;
      if (pending.size() == 0) begin
        report("unexpected item", got.x, '0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report("res_x", got.x, want.x);
      if (got.y !== want.y) report("res_y", got.y, want.y);
      if (got.z !== want.z) report("res_z", got.z, want.z);
      if (got.s !== want.s) report("res_scalar", got.s, want.s);
      if (got.st !== want.st) report("status", W'(got.st), W'(want.st));
    endtask
  endclass

  alu_scoreboard sb = new();

  // Offer one item after a random gap, wait for acceptance; valid drops for the gap, if any.
  task automatic send_item(input alu_req_t q, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1;
    opcode <= q.op;
    a_x <= q.ax; a_y <= q.ay; a_z <= q.az;
    b_x <= q.bx; b_y <= q.by; b_z <= q.bz;
    scale_factor <= q.sf;
    @(posedge clk);
    while (!ready) @(posedge clk);
    sb.note_item(q);
    op_hits[q.op]++;
  endtask

  function automatic comp_t rand_comp(input int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      2: return comp_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return '0;
    endcase
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    int m;
    m = $urandom_range(0, 9);
    m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 8) ? 2 : (m < 9) ? 3 : 4;
    q.op = op_t'($urandom_range(0, 7));
    q.ax = rand_comp(m); q.ay = rand_comp(m); q.az = rand_comp(m);
    q.bx = rand_comp(m); q.by = rand_comp(m); q.bz = rand_comp(m);
    q.sf = rand_comp(m);
    return q;
  endfunction

  function automatic alu_req_t mk(input op_t op, input comp_t av, input comp_t bv,
                                  input comp_t sv);
    alu_req_t q;
    q.op = op;
    q.ax = av; q.ay = av; q.az = av;
    q.bx = bv; q.by = bv; q.bz = bv;
    q.sf = sv;
    return q;
  endfunction

  // Receiver: random stalls, plus one long hold-off.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        res_ready <= 0;
      end else begin
        stall = $urandom_range(0, 3);
        if (stall != 0 && !stim_done && ($urandom_range(0, 7) != 0)) begin
          res_ready <= 0;
          repeat (stall - 1) @(posedge clk);
          @(posedge clk);
        end
        res_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result('{res_x, res_y, res_z, res_scalar, status_t'(status)});
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout with %0d items outstanding", sb.pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    alu_req_t q;
    comp_t maxv, minv, one;
    maxv = 32'sh7FFF_FFFF;
    minv = 32'sh8000_0000;
    one = 32'sh0001_0000;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: extremes, every op, saturation, zero-vector normalize.
    for (int o = 0; o < 8; o++) begin
      send_item(mk(op_t'(o), maxv, minv, maxv), 0);
      send_item(mk(op_t'(o), minv, minv, minv), 0);
    end
    send_item(mk(OP_NORM, '0, '0, '0), 0);
    send_item(mk(OP_NORM, 32'sd1, '0, '0), 0);
    send_item(mk(OP_MAG, one, one, one), 0);
    q = mk(OP_CROSS, one, -one, one);
    q.ay = '0; q.bz = 32'sh0002_0000;
    send_item(q, 0);
    send_item(mk(OP_SCALE, '0, 32'sh0003_8000, -one), 0);
    send_item(mk(OP_ADD, 32'sh4000_0000, 32'sh4000_0000, '0), 0);
    send_item(mk(OP_SUB, minv, 32'sd1, '0), 0);

    // Random; a long output hold-off partway through fills the pipe.
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 3) begin
        fork
          begin
            hold_off = 1;
            repeat (4 * LAT) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_item(rand_req(), (n % 200) > 150);
    end
    valid <= 0;
    stim_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);

    $display("Covered %0d items over all eight ops: add %0d sub %0d scale %0d dot %0d",
             N_RAND + 23, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("  cross %0d magsq %0d mag %0d normalize %0d, with backpressure and a full stall",
             op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> vector3_fixed_point_alu_top.f
rtl/vfa_pkg.sv
rtl/vfa_sqrt.sv
rtl/vfa_div.sv
rtl/vector3_fixed_point_alu_top.sv
sim/vector3_fixed_point_alu_top_tb.sv
